// ----- rtl/sector_crc_tracker_assert.svh -----
// Assertion macros for the sector CRC tracker RTL.
// Needs nothing else; define ASSERT_OFF to compile the checks out.
`ifndef SECTOR_CRC_TRACKER_ASSERT_SVH
`define SECTOR_CRC_TRACKER_ASSERT_SVH
`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is high.
`define SCT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define SCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCT_ASSERT(lbl, clk, rst, prop, msg)
`define SCT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/sct_pkg.sv -----
// Package for the sector CRC tracker: table size, CRC constants, kind codes
// and the lookup record that travels along the cell chain. Depends on nothing.
`timescale 1ns / 1ps

package sct_pkg;

   localparam int TABLE_ENTRIES = 128;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_CHECK = 1'b1
   } kind_type;

   // One sector lookup as it walks down the row of table cells.
   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [15:0] sector;
      logic [15:0] crc;
      logic        found;
      logic [15:0] stored;
      logic        appended;
   } query_type;

endpackage

// ----- rtl/sct_crc_fold.sv -----
// Folds one byte into a CRC-16/CCITT-FALSE value, MSB first, one bit per step.
// Depends on sct_pkg for the polynomial.
`timescale 1ns / 1ps

module sct_crc_fold (
   input  logic [15:0] crc_in,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_out
);
   import sct_pkg::*;

   always_comb begin
      logic [15:0] v;
      v = crc_in ^ {data_byte, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (v[15]) begin
            v = {v[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[14:0], 1'b0};
         end
      end
      crc_out = v;
   end

endmodule

// ----- rtl/sct_cell.sv -----
// One table entry of the sector CRC tracker plus its chain stage register.
// Depends on sct_pkg for query_type and the kind codes.
`timescale 1ns / 1ps

module sct_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                used,     // this entry lies below the fill count
   input  logic                slot,     // this entry is the next free one
   input  sct_pkg::query_type  q_in,
   output sct_pkg::query_type  q_out
);
   import sct_pkg::*;

   logic [15:0] tag_sector_ff, tag_sector_in;
   logic [15:0] tag_crc_ff, tag_crc_in;
   query_type   q_ff, q_in_next;
   logic        hit, take;

   // A used entry that matches takes the lookup if no lower entry did.
   assign hit  = q_in.valid && used && !q_in.found && (tag_sector_ff == q_in.sector);
   // The free entry receives a write that no used entry matched.
   assign take = q_in.valid && slot && !q_in.found && !q_in.appended
                 && (q_in.kind == KIND_WRITE);

   always_comb begin
      tag_sector_in = tag_sector_ff;
      tag_crc_in    = tag_crc_ff;
      q_in_next     = q_in;
      if (hit) begin
         q_in_next.found  = 1'b1;
         q_in_next.stored = tag_crc_ff;
         if (q_in.kind == KIND_WRITE) begin
            tag_crc_in = q_in.crc;
         end
      end else if (take) begin
         tag_sector_in      = q_in.sector;
         tag_crc_in         = q_in.crc;
         q_in_next.appended = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      tag_sector_ff <= tag_sector_in;
      tag_crc_ff    <= tag_crc_in;
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else begin
         q_ff <= q_in_next;
      end
   end

   assign q_out = q_ff;

endmodule

// ----- rtl/sector_crc_tracker.sv -----
// Top level of the sector CRC tracker: byte stream in, one result per sector.
// Depends on sct_pkg, sct_crc_fold, sct_cell and sector_crc_tracker_assert.svh.
`timescale 1ns / 1ps

//  Channel | Direction | Transaction moves
//  req_*   | in        | one sector byte, its sector number, kind and last mark
//  rsp_*   | out       | lookup result for one finished sector
//
//  A byte without tlast is folded into the running CRC, so a sector streams
//  at one byte per cycle. The byte with tlast launches a lookup, registered
//  in launch_ff, that steps through the row of TABLE_ENTRIES cells, one cell
//  per cycle; the result is registered after the last cell, and req_tready
//  stays low until the result transaction completes.
//  Reset is synchronous and active high; it restarts the CRC at 0xFFFF and
//  empties the table, and req_tready is low while it is held. A stall on
//  rsp_tready holds the result and keeps req closed.

module sector_crc_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] sector_number, [23:16] data_byte
   input  logic [0:0]  req_tuser,   // [0] kind
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [0] entry_found, [1] mismatch, [2] dropped_full,
                                    // [18:3] computed_crc, [34:19] stored_crc, rest zero
);
   import sct_pkg::*;

   logic              req_fire, rsp_fire;
   logic [15:0]       crc_next;
   logic [15:0]       running_crc_ff, running_crc_in;
   logic              busy_ff, busy_in;
   query_type         launch_ff, launch_in;
   query_type         chain [TABLE_ENTRIES+1];
   query_type         done;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [34:0]       rsp_data_ff, rsp_data_in;

   assign req_tready = !busy_ff && !reset;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;

   sct_crc_fold u_fold (
      .crc_in    (running_crc_ff),
      .data_byte (req_tdata[23:16]),
      .crc_out   (crc_next)
   );

   // Running CRC and launch of the lookup record on the last byte.
   always_comb begin
      running_crc_in = running_crc_ff;
      launch_in      = '0;
      if (req_fire) begin
         if (req_tlast) begin
            running_crc_in     = CRC_INIT;
            launch_in.valid    = 1'b1;
            launch_in.kind     = kind_type'(req_tuser[0]);
            launch_in.sector   = req_tdata[15:0];
            launch_in.crc      = crc_next;
         end else begin
            running_crc_in = crc_next;
         end
      end
   end

   // The lookup walks the row; each cell checks its own entry as it passes.
   assign chain[0] = launch_ff;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      localparam logic [CNT_W-1:0] CELL_IDX = CNT_W'(i);
      sct_cell u_cell (
         .clock (clock),
         .reset (reset),
         .used  (CELL_IDX < count_ff),
         .slot  (CELL_IDX == count_ff),
         .q_in  (chain[i]),
         .q_out (chain[i+1])
      );
   end

   assign done = chain[TABLE_ENTRIES];

   // Result capture, fill count and the busy window of one sector end.
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      busy_in      = busy_ff;
      if (req_fire && req_tlast) begin
         busy_in = 1'b1;
      end
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
         busy_in      = 1'b0;
      end
      if (done.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {done.stored,
                         done.crc,
                         (done.kind == KIND_WRITE) && !done.found && !done.appended,
                         (done.kind == KIND_CHECK) && done.found && (done.stored != done.crc),
                         done.found};
         if (done.appended) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff <= CRC_INIT;
         busy_ff        <= 1'b0;
         launch_ff      <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         running_crc_ff <= running_crc_in;
         busy_ff        <= busy_in;
         launch_ff      <= launch_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_data_ff};

`include "sector_crc_tracker_assert.svh"

   // A pending result always belongs to an open sector end.
   `SCT_ASSERT(a_rsp_in_busy, clock, reset, rsp_valid_ff |-> busy_ff, "result without busy window")
   // A lookup leaving the row never overwrites an untaken result.
   `SCT_ASSERT(a_no_overwrite, clock, reset, done.valid |-> !rsp_valid_ff, "result overwritten")
   // A last byte always launches exactly one lookup in the next cycle.
   `SCT_ASSERT(a_launch, clock, reset, (req_fire && req_tlast) |=> launch_ff.valid,
               "last byte did not launch a lookup")
   // Outside reset the fill count never passes the table size.
   `SCT_ASSERT_ALWAYS(a_count_range, clock, reset || (count_ff <= CNT_W'(TABLE_ENTRIES)),
                      "fill count beyond table size")

endmodule
